@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/swr_pkg.sv @@
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants of the sliding window RMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

  localparam int SAMPLE_IN_WIDTH = 16;  // width of the sample field on the bus
  localparam int RMS_WIDTH       = 16;  // width of the result field on the bus
  localparam int QUEUE_DEPTH     = 2;   // entries between front and back end

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ hdl/swr_queue.sv @@
// ----------------------------------------------------------------------------
// swr_queue
// Short register queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_queue #(
  parameter int DW = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DW-1:0]    push_data_i,
  input  wire logic             pop_i,
  output logic [DW-1:0]         pop_data_o,
  output swr_pkg::q_stat_t      stat_o
);

  localparam int PW = (swr_pkg::QUEUE_DEPTH > 1) ? $clog2(swr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(swr_pkg::QUEUE_DEPTH + 1);

  logic [DW-1:0] mem_q [swr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(swr_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(swr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(swr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/swr_front.sv @@
// ----------------------------------------------------------------------------
// swr_front
// Input side: takes sample beats, trims them to the sample width and tags
// each one as the warm-up beat or a beat that needs a fresh RMS.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [swr_pkg::SAMPLE_IN_WIDTH-1:0] s_axis_tdata_i,
  input  wire swr_pkg::q_stat_t                    q_stat_i,
  output logic                                     push_o,
  output logic [SAMPLE_WIDTH:0]                    push_data_o
);

  localparam int EXW = (SAMPLE_WIDTH > swr_pkg::SAMPLE_IN_WIDTH) ?
                       SAMPLE_WIDTH : swr_pkg::SAMPLE_IN_WIDTH;

  logic           warm_q;
  logic [EXW-1:0] ext;

  // bits above the sample width are dropped; a wider sample sees zeros above
  assign ext             = EXW'(s_axis_tdata_i);
  assign s_axis_tready_o = !q_stat_i.full;
  assign push_o          = s_axis_tvalid_i && !q_stat_i.full;
  assign push_data_o     = {warm_q, ext[SAMPLE_WIDTH-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= 1'b0;
    end else if (push_o) begin
      warm_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/swr_back.sv @@
// ----------------------------------------------------------------------------
// swr_back
// Execution side: shifts the window, accumulates the squares one slot a
// cycle and finds floor(sqrt(floor(sum / WINDOW))) one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_back #(
  parameter int WINDOW       = 5,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire swr_pkg::q_stat_t              q_stat_i,
  input  wire logic [SAMPLE_WIDTH:0]         q_data_i,
  output logic                               q_pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [swr_pkg::RMS_WIDTH-1:0]      m_axis_tdata_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int SB  = $clog2(WINDOW + 1);
  localparam int CW  = 2 * SW + SB + 2;
  localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int NW  = $clog2(WINDOW + 1);
  localparam int KW  = $clog2(SW);
  localparam int RXW = (SW > swr_pkg::RMS_WIDTH) ? SW : swr_pkg::RMS_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_OUT
  } state_e;

  state_e                        state_q;
  logic [SW-1:0]                 win_q [WINDOW];
  logic [NW-1:0]                 cnt_q;
  logic [2*SW-1:0]               sq_q;
  logic                          sq_v_q;
  logic [CW-1:0]                 acc_q, p_q, a_q, b_q;
  logic [KW-1:0]                 k_q;
  logic [SW-1:0]                 root_q;
  logic [swr_pkg::RMS_WIDTH-1:0] held_q, out_d_q;
  logic                          out_v_q;

  logic [SW-1:0]                 rd, mag;
  logic [CW-1:0]                 cand;
  logic                          fits;
  logic [SW-1:0]                 root_nx;
  logic [RXW-1:0]                root_x;
  logic [swr_pkg::RMS_WIDTH-1:0] rms_nx;

  assign rd      = win_q[cnt_q[IW-1:0]];
  assign mag     = rd[SW-1] ? (~rd + 1'b1) : rd;
  // trial root R + 2^k: W*(R+2^k)^2 = P + A + B, with A = W*R<<(k+1), B = W<<2k
  assign cand    = p_q + a_q + b_q;
  assign fits    = (cand <= acc_q);
  assign root_nx = {root_q[SW-2:0], fits};
  assign root_x  = RXW'(root_nx);
  assign rms_nx  = (root_x > RXW'({swr_pkg::RMS_WIDTH{1'b1}})) ? '1 :
                   root_x[swr_pkg::RMS_WIDTH-1:0];

  assign q_pop_o         = (state_q == S_IDLE) && !q_stat_i.empty;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= '0;
      end
      cnt_q   <= '0;
      sq_q    <= '0;
      sq_v_q  <= 1'b0;
      acc_q   <= '0;
      p_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      root_q  <= '0;
      held_q  <= '0;
      out_d_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      // the output state reloads the register itself
      if (out_v_q && m_axis_tready_i && (state_q != S_OUT)) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_stat_i.empty) begin
            for (int i = WINDOW - 1; i > 0; i--) begin
              win_q[i] <= win_q[i-1];
            end
            win_q[0] <= q_data_i[SW-1:0];
            if (q_data_i[SW]) begin
              cnt_q   <= '0;
              sq_v_q  <= 1'b0;
              acc_q   <= '0;
              state_q <= S_SQ;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_SQ: begin
          if (cnt_q != NW'(WINDOW)) begin
            sq_q   <= (2*SW)'(mag) * (2*SW)'(mag);
            sq_v_q <= 1'b1;
            cnt_q  <= cnt_q + 1'b1;
          end else begin
            // last square lands in the accumulator this cycle
            sq_v_q  <= 1'b0;
            p_q     <= '0;
            a_q     <= '0;
            b_q     <= CW'(WINDOW) << (2 * (SW - 1));
            k_q     <= KW'(SW - 1);
            root_q  <= '0;
            state_q <= S_ROOT;
          end
          if (sq_v_q) begin
            acc_q <= acc_q + CW'(sq_q);
          end
        end
        S_ROOT: begin
          root_q <= root_nx;
          if (fits) begin
            p_q <= cand;
            a_q <= (a_q >> 1) + b_q;
          end else begin
            a_q <= a_q >> 1;
          end
          b_q <= b_q >> 2;
          if (k_q == '0) begin
            held_q  <= rms_nx;
            state_q <= S_OUT;
          end else begin
            k_q <= k_q - 1'b1;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_v_q || m_axis_tready_i) begin
            out_v_q <= 1'b1;
            out_d_q <= held_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/sliding_window_rms.sv @@
// ----------------------------------------------------------------------------
// sliding_window_rms
// Moving-window RMS of a signed sample stream, floored integer result.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one signed sample per beat; master channel
//   m_axis_* returns exactly one RMS value per accepted sample, in order.
//   Each sample enters a window of the last WINDOW samples (zero after reset)
//   and the result is floor(sqrt(floor(sum of squares / WINDOW))). The first
//   beat after reset only fills the window and returns zero.
// Back-end pass:
//   A computed beat makes one squarer pass over the window slots in the back
//   end, then gets one root bit per cycle from the shared add-and-compare
//   unit. The warm-up beat skips both and goes straight to the output. The
//   back end takes one beat per pass; meanwhile the queue takes the next.
// Reset and stalls:
//   rst_ni clears the window, the held result, the queue and the output
//   register. When the receiver stalls, the result stays in the output
//   register, the back end parks on its next result, and the front end keeps
//   taking beats until its small queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rms #(
  parameter int WINDOW       = 5,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [swr_pkg::SAMPLE_IN_WIDTH-1:0] s_axis_tdata_i,  // [15:0] sample
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [swr_pkg::RMS_WIDTH-1:0]            m_axis_tdata_o   // [15:0] rms_value
);

  swr_pkg::q_stat_t        q_stat;
  logic                    push, pop;
  logic [SAMPLE_WIDTH:0]   push_data, pop_data;

  swr_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  swr_queue #(
    .DW (SAMPLE_WIDTH + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  swr_back #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .q_data_i        (pop_data),
    .q_pop_o         (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ hdl/swr_checker.sv @@
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks of the sliding window RMS block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swr_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid_i,
  input wire logic                                s_axis_tready_o,
  input wire logic                                m_axis_tvalid_o,
  input wire logic                                m_axis_tready_i,
  input wire logic [swr_pkg::RMS_WIDTH-1:0]       m_axis_tdata_o
);

  localparam int CAP = swr_pkg::QUEUE_DEPTH + 2;
  localparam int FW  = $clog2(CAP + 2);

  logic [FW-1:0] flight_q;
  logic          seen_q;
  logic          in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // beats taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
      seen_q   <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        flight_q <= flight_q + 1'b1;
      end else if (out_acc && !in_acc) begin
        flight_q <= flight_q - 1'b1;
      end
      if (out_acc) begin
        seen_q <= 1'b1;
      end
    end
  end

  `SWR_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `SWR_ASSERT_NOW(a_no_orphan, m_axis_tvalid_o, flight_q != '0, "result without a sample")
  `SWR_ASSERT_NOW(a_bounded, 1'b1, flight_q <= FW'(CAP), "too many samples in flight")
  `SWR_ASSERT_NOW(a_first_zero, out_acc && !seen_q, m_axis_tdata_o == '0,
                  "first result after reset not zero")

endmodule

bind sliding_window_rms swr_checker u_swr_checker (.*);

`default_nettype wire

@@ tb/tb_sliding_window_rms.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_rms
// Self-checking bench for the moving-window RMS block.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream and RMS values come back on the master
// stream. A behavioural model of the window, the held result and the warm-up
// flag predicts each value when its sample is accepted. The checker compares
// every returned beat with the oldest prediction. The stimulus runs through
// several idle and stall mixes: a directed set of extremes, then random
// streams, with one pause that lets the block drain completely.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_sliding_window_rms;

  localparam int WIN_LEN    = 5;
  localparam int SMP_W      = swr_pkg::SAMPLE_IN_WIDTH;
  localparam int RMS_W      = swr_pkg::RMS_WIDTH;
  localparam int PASS_CYCLE = WIN_LEN + SMP_W + 3;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic [SMP_W-1:0] s_tdata = '0;
  logic             m_tready = 1'b0;
  wire              s_tready;
  wire              m_tvalid;
  wire  [RMS_W-1:0] m_tdata;

  // Bench model of the block
  logic signed [SMP_W-1:0] window_q [WIN_LEN];
  logic [RMS_W-1:0]        held_rms_q;
  logic                    warm_q;
  logic [RMS_W-1:0]        rms_expected [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int err_count = 0;

  sliding_window_rms #(
    .WINDOW      (WIN_LEN),
    .SAMPLE_WIDTH(SMP_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [15:0] sample
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)    // [15:0] rms_value
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Shift the sample in and return the value the block should report
  function automatic logic [RMS_W-1:0] rms_after(input logic signed [SMP_W-1:0] smp);
    longint      sum_sq;
    longint      mag;
    logic [63:0] root;
    sum_sq = 0;
    for (int i = WIN_LEN - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = smp;
    if (warm_q) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        mag = longint'(window_q[i]);
        sum_sq += mag * mag;
      end
      root = floor_root(64'(sum_sq / WIN_LEN));
      held_rms_q = (root > 64'hFFFF) ? '1 : root[RMS_W-1:0];
    end
    warm_q = 1'b1;
    return held_rms_q;
  endfunction

  task automatic send_sample(input logic signed [SMP_W-1:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk_i); while (!s_tready);
    rms_expected.push_back(rms_after(smp));
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return {1'b1, {(SMP_W-1){1'b0}}};
      1:       return {1'b0, {(SMP_W-1){1'b1}}};
      2:       return SMP_W'($signed($urandom_range(32)) - 16);
      3:       return '0;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  // Receiver side: stall at the current rate
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (rms_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected beat: rms %0d", m_tdata);
      end else begin
        if (m_tdata !== rms_expected[0]) begin
          err_count++;
          if (err_count <= 10) begin
            $display("rms mismatch: expected %0d, got %0d", rms_expected[0], m_tdata);
          end
        end
        void'(rms_expected.pop_front());
      end
    end
  end

  // Hold the sender until every outstanding result has returned
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rms_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_first_beat();
    send_sample(16'sh8000);
  endtask

  task automatic test_extremes();
    for (int i = 0; i < 4; i++) send_sample(16'sh8000);
    for (int i = 0; i < 5; i++) send_sample(16'sh7FFF);
    for (int i = 0; i < 5; i++) send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh0002);
    send_sample(16'shFFFE);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
  endtask

  task automatic test_random_stream(input int idle, input int stall, input int count);
    logic signed [SMP_W-1:0] smp;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      // Now and then fill the whole window with one value
      if ($urandom_range(19) == 0) begin
        smp = pick_sample();
        for (int k = 0; k < WIN_LEN; k++) send_sample(smp);
        n += WIN_LEN - 1;
      end else begin
        send_sample(pick_sample());
      end
    end
  endtask

  task automatic test_drain_pause();
    test_random_stream(0, 0, 20);
    drain_pause();
    test_random_stream(0, 0, 20);
  endtask

  initial begin
    for (int i = 0; i < WIN_LEN; i++) window_q[i] = '0;
    held_rms_q = '0;
    warm_q     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_beat();
    test_extremes();
    test_random_stream(0, 0, 280);
    test_random_stream(63, 0, 280);
    test_drain_pause();
    test_random_stream(0, 63, 280);
    test_random_stream(17, 17, 280);
    s_tvalid <= 1'b0;

    while (rms_expected.size() != 0) @(posedge clk_i);
    repeat (3 * PASS_CYCLE + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/swr_pkg.sv
hdl/swr_queue.sv
hdl/swr_front.sv
hdl/swr_back.sv
hdl/sliding_window_rms.sv
hdl/swr_checker.sv
tb/tb_sliding_window_rms.sv
